@@ design/gcar_pkg.sv @@
// Shared types and constants of the glyph cache age replacement engine.
package gcar_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned KeyW         = 21;
  localparam int unsigned AgeW         = 8;
  localparam int unsigned SlotW        = 4;
  localparam int unsigned IdxMaxW      = 8;

  localparam logic [AgeW-1:0] AgeMax   = 8'hFF;
  localparam logic [KeyW-1:0] KeyEmpty = '0;

  typedef enum logic [1:0] {
    StHit    = 2'd0,
    StFill   = 2'd1,
    StAbsent = 2'd2,
    StBlank  = 2'd3
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [AgeW-1:0] age;
  } entry_t;

endpackage

@@ design/glyph_cache_age_replacement.sv @@
// Top level: request sequencer of the glyph cache tag and replacement engine.
//
// One request at a time. A request scans the slot memory once, one slot per
// cycle through its single read port, to find a hit, the first empty slot and
// the first oldest slot. On a miss for a stored glyph with no empty slot, a
// second read-modify-write pass ages every slot. Codepoint zero is answered
// as absent without touching the memory. The result sits in an output
// register, so a new request is taken while a result still waits. After
// reset all slots read as empty.
module glyph_cache_age_replacement #(
  parameter int unsigned SLOTS = gcar_pkg::SlotsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [gcar_pkg::KeyW-1:0] codepoint_i,
  input  logic                      glyph_in_store_i,
  input  logic                      glyph_blank_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [gcar_pkg::SlotW-1:0] slot_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [CntW-1:0] CntEnd = CntW'(SLOTS);

  typedef enum logic [5:0] {
    SIdle   = 6'b000001,
    SScan   = 6'b000010,
    SDecide = 6'b000100,
    SAge    = 6'b001000,
    SFin    = 6'b010000,
    SResp   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rd_pend_q, rd_pend_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;

  logic [gcar_pkg::KeyW-1:0] cp_q, cp_d;
  logic                      in_store_q, in_store_d;
  logic                      blank_q, blank_d;

  logic                      hit_q, hit_d;
  logic [IdxW-1:0]           hit_idx_q, hit_idx_d;
  logic                      emp_q, emp_d;
  logic [IdxW-1:0]           emp_idx_q, emp_idx_d;
  logic [gcar_pkg::AgeW-1:0] best_age_q, best_age_d;
  logic [IdxW-1:0]           best_idx_q, best_idx_d;

  gcar_pkg::status_e         fin_status_q, fin_status_d;
  logic [IdxW-1:0]           fin_idx_q, fin_idx_d;

  logic                      out_valid_q, out_valid_d;
  gcar_pkg::status_e         res_status_q, res_status_d;
  logic [IdxW-1:0]           res_idx_q, res_idx_d;

  logic                      mem_we;
  logic [IdxW-1:0]           mem_waddr;
  gcar_pkg::entry_t          mem_wdata;
  logic                      mem_re;
  gcar_pkg::entry_t          mem_rdata;

  logic [gcar_pkg::IdxMaxW-1:0] res_idx_wide;

  gcar_slot_mem #(
    .Slots (SLOTS),
    .IdxW  (IdxW)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (mem_rdata)
  );

  // Sequence the scan, aging pass and write-back
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_pend_d    = 1'b0;
    rd_idx_d     = cnt_q[IdxW-1:0];
    cp_d         = cp_q;
    in_store_d   = in_store_q;
    blank_d      = blank_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    emp_d        = emp_q;
    emp_idx_d    = emp_idx_q;
    best_age_d   = best_age_q;
    best_idx_d   = best_idx_q;
    fin_status_d = fin_status_q;
    fin_idx_d    = fin_idx_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mem_we       = 1'b0;
    mem_waddr    = hit_idx_q;
    mem_wdata    = '{key: cp_q, age: '0};
    mem_re       = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cp_d       = codepoint_i;
          in_store_d = glyph_in_store_i;
          blank_d    = glyph_blank_i;
          hit_d      = 1'b0;
          emp_d      = 1'b0;
          best_age_d = '0;
          best_idx_d = '0;
          cnt_d      = '0;
          if (codepoint_i == gcar_pkg::KeyEmpty) begin
            fin_status_d = gcar_pkg::StAbsent;
            fin_idx_d    = '0;
            state_d      = SResp;
          end else begin
            state_d = SScan;
          end
        end
      end

      SScan: begin
        // Issue the next read
        if (cnt_q != CntEnd) begin
          mem_re    = 1'b1;
          rd_pend_d = 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end
        // Examine the slot read last cycle
        if (rd_pend_q) begin
          if (!hit_q && mem_rdata.key == cp_q) begin
            hit_d     = 1'b1;
            hit_idx_d = rd_idx_q;
          end
          if (!emp_q && mem_rdata.key == gcar_pkg::KeyEmpty) begin
            emp_d     = 1'b1;
            emp_idx_d = rd_idx_q;
          end
          if (mem_rdata.age > best_age_q) begin
            best_age_d = mem_rdata.age;
            best_idx_d = rd_idx_q;
          end
        end else if (cnt_q == CntEnd) begin
          state_d = SDecide;
        end
      end

      SDecide: begin
        priority if (hit_q) begin
          mem_we       = 1'b1;
          mem_waddr    = hit_idx_q;
          fin_status_d = gcar_pkg::StHit;
          fin_idx_d    = hit_idx_q;
          state_d      = SResp;
        end else if (!in_store_q) begin
          fin_status_d = gcar_pkg::StAbsent;
          fin_idx_d    = '0;
          state_d      = SResp;
        end else if (emp_q) begin
          fin_idx_d = emp_idx_q;
          if (blank_q) begin
            fin_status_d = gcar_pkg::StBlank;
          end else begin
            mem_we       = 1'b1;
            mem_waddr    = emp_idx_q;
            fin_status_d = gcar_pkg::StFill;
          end
          state_d = SResp;
        end else begin
          cnt_d   = '0;
          state_d = SAge;
        end
      end

      SAge: begin
        // Read each slot, write back its age advanced by one, saturating
        if (cnt_q != CntEnd) begin
          mem_re    = 1'b1;
          rd_pend_d = 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end
        if (rd_pend_q) begin
          mem_we        = 1'b1;
          mem_waddr     = rd_idx_q;
          mem_wdata.key = mem_rdata.key;
          mem_wdata.age = (mem_rdata.age == gcar_pkg::AgeMax) ? mem_rdata.age
                                                              : mem_rdata.age + 1'b1;
        end else if (cnt_q == CntEnd) begin
          state_d = SFin;
        end
      end

      SFin: begin
        fin_idx_d = best_idx_q;
        if (blank_q) begin
          fin_status_d = gcar_pkg::StBlank;
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = best_idx_q;
          fin_status_d = gcar_pkg::StFill;
        end
        state_d = SResp;
      end

      SResp: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          res_status_d = fin_status_q;
          res_idx_d    = fin_idx_q;
          state_d      = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and scan payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    cp_q         <= cp_d;
    in_store_q   <= in_store_d;
    blank_q      <= blank_d;
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    emp_q        <= emp_d;
    emp_idx_q    <= emp_idx_d;
    best_age_q   <= best_age_d;
    best_idx_q   <= best_idx_d;
    fin_status_q <= fin_status_d;
    fin_idx_q    <= fin_idx_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
  end

  // Drive the ports
  assign res_idx_wide = gcar_pkg::IdxMaxW'(res_idx_q);
  assign in_stall_o   = (state_q != SIdle);
  assign out_valid_o  = out_valid_q;
  assign status_o     = res_status_q;
  assign slot_o       = res_idx_wide[gcar_pkg::SlotW-1:0];

endmodule

@@ design/gcar_slot_mem.sv @@
// Slot memory: key and age per slot, one write port, one registered read port.
module gcar_slot_mem #(
  parameter int unsigned Slots = gcar_pkg::SlotsDefault,
  parameter int unsigned IdxW  = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  gcar_pkg::entry_t    wdata_i,
  input  logic                re_i,
  input  logic [IdxW-1:0]     raddr_i,
  output gcar_pkg::entry_t    rdata_o
);

  gcar_pkg::entry_t mem_q [Slots];
  gcar_pkg::entry_t rdata_q;
  logic [Slots-1:0] written_q;
  logic             rvalid_q;

  // Write the entry array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Track written entries so never-written slots read as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= written_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule
